@@ src/gdsf_pkg.sv @@
// Package: span and word transaction types, queue entry type and shared constants.
package gdsf_pkg;

	localparam int HALF_ROWS_DEF     = 32;
	localparam int WORDS_PER_ROW_DEF = 8;
	localparam int PIX_PER_WORD      = 16;
	localparam int SPAN_QUEUE_DEPTH  = 2;

	localparam logic [15:0] FULL_WORD   = 16'hFFFF;
	localparam logic [3:0]  LAST_BIT_IX = 4'd15;

	typedef struct packed {
		logic [5:0] row;
		logic [6:0] first_col;
		logic [6:0] last_col;
		logic       set_pixels;
	} span_t;

	typedef struct packed {
		logic [4:0]  vert_addr;
		logic [3:0]  horiz_addr;
		logic [15:0] word_data;
		logic        last_word;
	} word_t;

	// Classified span as it waits between front and back.
	typedef struct packed {
		logic [5:0] row;
		logic [4:0] vert;
		logic       half;
		logic [2:0] first_word;
		logic [2:0] last_word;
		logic [3:0] lo_bit;
		logic [3:0] hi_bit;
		logic       set_pixels;
	} span_entry_t;

endpackage

@@ src/gdsf_front.sv @@
// Front end: accept spans, wrap and split the row, clip columns, drop empty spans.
module gdsf_front #(
	parameter int HALF_ROWS     = gdsf_pkg::HALF_ROWS_DEF,
	parameter int WORDS_PER_ROW = gdsf_pkg::WORDS_PER_ROW_DEF
) (
	input  logic                  span_valid,
	output logic                  span_stall,
	input  gdsf_pkg::span_t       span,
	input  logic                  clearing,
	input  logic                  q_full,
	output logic                  push,
	output gdsf_pkg::span_entry_t push_entry
);

	localparam int NUM_ROWS = 2 * HALF_ROWS;
	localparam int NUM_COLS = WORDS_PER_ROW * gdsf_pkg::PIX_PER_WORD;

	logic [7:0] row_ext;
	logic [7:0] row_wrap;
	logic [7:0] vert_full;
	logic       half;
	logic [8:0] lc_ext;
	logic [8:0] lc_sat_ext;
	logic [6:0] lc_sat;
	logic       empty_span;

	assign row_ext  = {2'b00, span.row};
	assign row_wrap = (row_ext >= 8'(NUM_ROWS)) ? row_ext - 8'(NUM_ROWS) : row_ext;
	assign half      = (row_wrap >= 8'(HALF_ROWS));
	assign vert_full = half ? row_wrap - 8'(HALF_ROWS) : row_wrap;

	assign lc_ext     = {2'b00, span.last_col};
	assign lc_sat_ext = (lc_ext > 9'(NUM_COLS - 1)) ? 9'(NUM_COLS - 1) : lc_ext;
	assign lc_sat     = lc_sat_ext[6:0];
	assign empty_span = (span.first_col > lc_sat);

	assign span_stall = q_full || clearing;
	assign push       = span_valid && !span_stall && !empty_span;

	always_comb begin
		push_entry            = '0;
		push_entry.row        = row_wrap[5:0];
		push_entry.vert       = vert_full[4:0];
		push_entry.half       = half;
		push_entry.first_word = span.first_col[6:4];
		push_entry.last_word  = lc_sat[6:4];
		push_entry.lo_bit     = span.first_col[3:0];
		push_entry.hi_bit     = lc_sat[3:0];
		push_entry.set_pixels = span.set_pixels;
	end

endmodule

@@ src/gdsf_queue.sv @@
// Span queue: short FIFO of classified spans between front and back.
module gdsf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  gdsf_pkg::span_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output gdsf_pkg::span_entry_t head,
	output logic                  head_valid
);

	localparam int DEPTH = gdsf_pkg::SPAN_QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gdsf_pkg::span_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("span queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("span queue popped while empty");
`endif

endmodule

@@ src/gdsf_back.sv @@
// Back end: word sequencer, shadow memory read-modify-write and output register.
module gdsf_back #(
	parameter int HALF_ROWS     = gdsf_pkg::HALF_ROWS_DEF,
	parameter int WORDS_PER_ROW = gdsf_pkg::WORDS_PER_ROW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gdsf_pkg::span_entry_t head,
	input  logic                  head_valid,
	output logic                  pop,
	output logic                  clearing,
	output logic                  word_valid,
	input  logic                  word_stall,
	output gdsf_pkg::word_t       word
);

	localparam int STORE_WORDS = 2 * HALF_ROWS * WORDS_PER_ROW;
	localparam int IDX_W       = $clog2(STORE_WORDS);

	logic [15:0] shadow_mem [STORE_WORDS];

	logic             clearing_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             in_span_q;
	logic [2:0]       w_q;

	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [15:0]      mask_s1;
	logic             set_s1;
	logic [4:0]       vert_s1;
	logic [3:0]       horiz_s1;
	logic             last_s1;
	logic [15:0]      rd_s1;

	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [15:0]      fwd_data_q;

	logic             out_valid_q;
	gdsf_pkg::word_t  out_q;

	logic             adv;
	logic             issue;
	logic [2:0]       cur_w;
	logic             cur_last;
	logic [3:0]       lo;
	logic [3:0]       hi;
	logic [15:0]      issue_mask;
	logic [IDX_W-1:0] issue_idx;
	logic [3:0]       issue_horiz;
	logic [15:0]      old_word;
	logic [15:0]      new_word;
	logic             wr_en;

	// Issue: a word address per cycle from the head span unless stalled or clearing.
	assign adv      = !out_valid_q || !word_stall;
	assign cur_w    = in_span_q ? w_q : head.first_word;
	assign cur_last = (cur_w == head.last_word);
	assign issue    = head_valid && adv && !clearing_q;
	assign pop      = issue && cur_last;

	assign lo = (cur_w == head.first_word) ? head.lo_bit : 4'd0;
	assign hi = cur_last ? head.hi_bit : gdsf_pkg::LAST_BIT_IX;
	assign issue_mask = (gdsf_pkg::FULL_WORD >> lo)
		& (gdsf_pkg::FULL_WORD << (gdsf_pkg::LAST_BIT_IX - hi));
	assign issue_idx = IDX_W'(32'(head.row) * 32'(WORDS_PER_ROW) + 32'(cur_w));
	assign issue_horiz = 4'(32'(cur_w) + (head.half ? 32'(WORDS_PER_ROW) : 32'd0));

	// Modify side: take the last write when it hit the same word.
	assign old_word = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rd_s1;
	assign new_word = set_s1 ? (old_word | mask_s1) : (old_word & ~mask_s1);
	assign wr_en    = valid_s1 && adv;

	assign clearing   = clearing_q;
	assign word_valid = out_valid_q;
	assign word       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			in_span_q   <= 1'b0;
			w_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_idx_q == IDX_W'(STORE_WORDS - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + 1'b1;
				end
			end
			if (issue) begin
				in_span_q <= !cur_last;
				w_q       <= cur_w + 3'd1;
			end
			if (adv) begin
				valid_s1    <= issue;
				out_valid_q <= valid_s1;
			end
			if (clearing_q) begin
				fwd_valid_q <= 1'b0;
			end else if (wr_en) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= issue_idx;
			mask_s1  <= issue_mask;
			set_s1   <= head.set_pixels;
			vert_s1  <= head.vert;
			horiz_s1 <= issue_horiz;
			last_s1  <= cur_last;
		end
		if (wr_en) begin
			fwd_idx_q            <= idx_s1;
			fwd_data_q           <= new_word;
			out_q.vert_addr      <= vert_s1;
			out_q.horiz_addr     <= horiz_s1;
			out_q.word_data      <= new_word;
			out_q.last_word      <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			shadow_mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			shadow_mem[idx_s1] <= new_word;
		end
		if (adv) begin
			rd_s1 <= shadow_mem[issue_idx];
		end
	end

`ifndef SYNTHESIS
	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!valid_s1 && !out_valid_q))
		else $error("word in flight during shadow clear");
	a_span_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		in_span_q |-> head_valid)
		else $error("mid-span with empty queue");
`endif

endmodule

@@ src/gdram_span_fill_unit.sv @@
// Top level: span fill unit for a one-bit display with a shadow of its word memory.
//
//   channel | direction | payload           | handshake
//   span    | in        | gdsf_pkg::span_t  | span_valid / span_stall
//   word    | out       | gdsf_pkg::word_t  | word_valid / word_stall
//
// A span touching n words (1 to 8) takes one shadow read-modify-write per word in the
// back end, one per cycle unless the output stalls, with one read and one write port;
// reads are registered in s1, new words in the output register. Empty spans are
// dropped in the front end. After reset a clearing pass writes zeros, one per cycle,
// over all 2*HALF_ROWS*WORDS_PER_ROW words (512 by default); span_stall is held high.
// Once clearing is done, span_stall rises only when the span queue is full; a stalled
// word output holds the back end, and the queue absorbs up to two spans meanwhile.
module gdram_span_fill_unit #(
	parameter int HALF_ROWS     = gdsf_pkg::HALF_ROWS_DEF,
	parameter int WORDS_PER_ROW = gdsf_pkg::WORDS_PER_ROW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            span_valid,
	output logic            span_stall,
	input  gdsf_pkg::span_t span,
	output logic            word_valid,
	input  logic            word_stall,
	output gdsf_pkg::word_t word
);

	gdsf_pkg::span_entry_t push_entry;
	gdsf_pkg::span_entry_t head;
	logic                  push;
	logic                  q_full;
	logic                  pop;
	logic                  head_valid;
	logic                  clearing;

	// Classify each span transaction and push the non-empty ones.
	gdsf_front #(
		.HALF_ROWS     (HALF_ROWS),
		.WORDS_PER_ROW (WORDS_PER_ROW)
	) u_front (
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span),
		.clearing   (clearing),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple acceptance from the word loop.
	gdsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Walk the words of the head span, update the shadow, emit each word.
	gdsf_back #(
		.HALF_ROWS     (HALF_ROWS),
		.WORDS_PER_ROW (WORDS_PER_ROW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.clearing   (clearing),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

endmodule

@@ tb/gdsf_span_checker.sv @@
// Checker: shadow display predictor and word transaction scoreboard for the span fill unit.
module gdsf_span_checker
#(
	parameter int HALF_ROWS     = gdsf_pkg::HALF_ROWS_DEF,
	parameter int WORDS_PER_ROW = gdsf_pkg::WORDS_PER_ROW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            span_valid,
	input  logic            span_stall,
	input  gdsf_pkg::span_t span,
	input  logic            word_valid,
	input  logic            word_stall,
	input  gdsf_pkg::word_t word,
	output int              fail_count,
	output int              words_pending,
	output int              words_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import gdsf_pkg::*;

	localparam int NUM_ROWS    = 2 * HALF_ROWS;
	localparam int NUM_COLS    = WORDS_PER_ROW * PIX_PER_WORD;
	localparam int STORE_WORDS = NUM_ROWS * WORDS_PER_ROW;

	logic [15:0] display_shadow [STORE_WORDS];
	word_t       expected_words [$];

	// Apply one span to the shadow and queue the words it writes, left to right.
	task automatic fill_span(input span_t s);
		int unsigned row, fc, lc, fw, lw, cw, lo, hi, idx;
		logic [15:0] mask;
		logic [15:0] cur;
		word_t       w_exp;
		row = s.row % NUM_ROWS;
		fc  = s.first_col;
		lc  = (s.last_col > NUM_COLS - 1) ? NUM_COLS - 1 : s.last_col;
		if (fc > lc) return;
		fw = fc / PIX_PER_WORD;
		lw = lc / PIX_PER_WORD;
		for (cw = fw; cw <= lw; cw++) begin
			lo   = (cw == fw) ? fc % PIX_PER_WORD : 0;
			hi   = (cw == lw) ? lc % PIX_PER_WORD : LAST_BIT_IX;
			mask = (FULL_WORD >> lo) & (FULL_WORD << (LAST_BIT_IX - hi));
			idx  = row * WORDS_PER_ROW + cw;
			if (idx >= STORE_WORDS) break;
			cur = s.set_pixels ? (display_shadow[idx] | mask) : (display_shadow[idx] & ~mask);
			display_shadow[idx] = cur;
			w_exp.vert_addr  = 5'(row % HALF_ROWS);
			w_exp.horiz_addr = 4'(cw + (row / HALF_ROWS) * WORDS_PER_ROW);
			w_exp.word_data  = cur;
			w_exp.last_word  = (cw == lw);
			expected_words.push_back(w_exp);
		end
	endtask

	function automatic int field_differs(string name, logic [15:0] want, logic [15:0] got);
		if (got === want) return 0;
		$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		return 1;
	endfunction

	task automatic check_word(input word_t got);
		word_t want;
		if (expected_words.size() == 0) begin
			$error("word transaction with nothing expected: 0x%0h", got);
			fail_count++;
			return;
		end
		want = expected_words.pop_front();
		words_checked++;
		fail_count += field_differs("vert_addr", want.vert_addr, got.vert_addr);
		fail_count += field_differs("horiz_addr", want.horiz_addr, got.horiz_addr);
		fail_count += field_differs("word_data", want.word_data, got.word_data);
		fail_count += field_differs("last_word", want.last_word, got.last_word);
	endtask

	initial begin
		fail_count    = 0;
		words_pending = 0;
		words_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			foreach (display_shadow[i]) display_shadow[i] = '0;
			words_pending <= 0;
		end else begin
			if (span_valid && !span_stall) fill_span(span);
			if (word_valid && !word_stall) check_word(word);
			words_pending <= expected_words.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, span stimulus, word stall pattern and final verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gdsf_pkg::*;

	localparam int SPAN_COUNT   = 320;        // spans to offer in total
	localparam int QUIET_SPANS  = 40;         // final spans run with no idling at all
	localparam int HOLD_CYCLES  = 240;        // long output hold-off, fills the span queue
	localparam int RUN_LIMIT_NS = 2_000_000;  // many times the slowest legal run

	logic  clk         = 1'b0;
	logic  arst_n      = 1'b0;
	logic  span_valid  = 1'b0;
	logic  span_stall;
	span_t span        = '0;
	logic  word_valid;
	logic  word_stall  = 1'b0;
	word_t word;

	bit    quiet_tail    = 1'b0;
	bit    sender_choppy = 1'b1;
	bit    hold_off_req  = 1'b0;
	int    spans_sent    = 0;
	int    empty_spans   = 0;
	int    filled_spans  = 0;
	int    fail_count;
	int    words_pending;
	int    words_checked;

	gdram_span_fill_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

	gdsf_span_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.span_valid    (span_valid),
		.span_stall    (span_stall),
		.span          (span),
		.word_valid    (word_valid),
		.word_stall    (word_stall),
		.word          (word),
		.fail_count    (fail_count),
		.words_pending (words_pending),
		.words_checked (words_checked)
	);

	always #5 clk = ~clk;

	function automatic span_t make_span(int r, int fc, int lc, int set_bit);
		span_t s;
		s.row        = 6'(r);
		s.first_col  = 7'(fc);
		s.last_col   = 7'(lc);
		s.set_pixels = 1'(set_bit);
		return s;
	endfunction

	// Pick a span shape. Half of the spans land on rows 30..33 so the same
	// words get modified again and again across the half boundary.
	function automatic span_t random_span();
		int kind, r, a, b;
		kind = $urandom_range(0, 99);
		r    = $urandom_range(0, 1) ? $urandom_range(0, 63) : 30 + $urandom_range(0, 3);
		if (kind < 35) begin
			// short span, often inside one word or just over an edge
			a = $urandom_range(0, 127);
			b = a + $urandom_range(0, 17);
			if (b > 127) b = 127;
		end else if (kind < 60) begin
			a = $urandom_range(0, 127);
			b = $urandom_range(a, 127);
		end else if (kind < 75) begin
			// nearly the whole row
			a = $urandom_range(0, 7);
			b = 127 - $urandom_range(0, 7);
		end else if (kind < 85) begin
			// reversed span, dropped by the block
			a = $urandom_range(1, 127);
			b = $urandom_range(0, a - 1);
		end else begin
			a = $urandom_range(0, 127);
			b = $urandom_range(0, 127);
		end
		return make_span(r, a, b, $urandom_range(0, 1));
	endfunction

	// Present one span transaction and hold it until the block takes it.
	// Leave span_valid high so a following call streams back to back.
	task automatic offer_span(input span_t s);
		span       <= s;
		span_valid <= 1'b1;
		do @(posedge clk); while (span_stall);
		spans_sent++;
		if (s.first_col > s.last_col) empty_spans++;
		else filled_spans++;
	endtask

	// Drop valid for a random burst, except in calm stretches and the tail.
	task automatic maybe_idle();
		if (!quiet_tail && sender_choppy && $urandom_range(0, 3) == 0) begin
			span_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted word has come out.
	task automatic drain_words();
		span_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	// Receiver side: stall in random bursts whose density changes per segment,
	// with segments that never stall. On request, hold off for a long stretch
	// so the block backs up and stalls its span input.
	initial begin : word_stall_gen
		int stall_pct;
		int seg_left;
		stall_pct = 0;
		seg_left  = 0;
		forever begin
			@(posedge clk);
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			seg_left--;
			if (hold_off_req) begin
				word_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				word_stall   <= 1'b0;
				hold_off_req <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
				word_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				word_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		bit hold_done;
		bit pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		// Hold reset, then release it once. The block runs its clearing pass next with
		// span_stall high; offer_span just waits it out.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed spans: field extremes, word edges, both halves, reversed spans.
		offer_span(make_span(0, 0, 127, 1));     // full row, all eight words
		offer_span(make_span(0, 0, 0, 0));       // clear the leftmost pixel only
		offer_span(make_span(0, 127, 127, 0));   // clear the rightmost pixel only
		offer_span(make_span(63, 0, 127, 1));    // last row, lower half addressing
		offer_span(make_span(63, 127, 127, 0));
		offer_span(make_span(31, 5, 9, 1));      // inside one word, last upper row
		offer_span(make_span(32, 15, 16, 1));    // straddle a word edge, first lower row
		offer_span(make_span(32, 16, 15, 1));    // reversed by one column
		offer_span(make_span(10, 100, 3, 1));    // reversed, far apart
		offer_span(make_span(0, 127, 0, 0));     // reversed, extreme columns
		offer_span(make_span(33, 17, 30, 1));    // interior mask, both edges in one word
		offer_span(make_span(33, 20, 25, 0));    // clear a hole in what was just set
		offer_span(make_span(63, 120, 127, 1));
		offer_span(make_span(1, 0, 15, 1));      // exactly one aligned word
		offer_span(make_span(1, 112, 127, 0));
		offer_span(make_span(31, 0, 127, 0));    // clear a row that holds pixels
		offer_span(make_span(45, 8, 119, 1));    // partial words at both ends
		offer_span(make_span(45, 9, 118, 0));
		offer_span(make_span(5, 63, 63, 1));     // single pixels on either side of mid-row
		offer_span(make_span(5, 64, 64, 1));
		offer_span(make_span(2, 42, 42, 1));
		drain_words();

		// Random spans with the long hold-off and one full drain along the way.
		while (spans_sent < SPAN_COUNT) begin
			if (!hold_done && spans_sent >= 120) begin
				hold_done = 1'b1;
				hold_off_req <= 1'b1;
				// keep offering wide spans so the queue fills behind the stalled output
				repeat (14) offer_span(make_span($urandom_range(0, 63), $urandom_range(0, 3),
					127 - $urandom_range(0, 3), $urandom_range(0, 1)));
			end
			if (!pause_done && spans_sent >= 220) begin
				pause_done = 1'b1;
				drain_words();
			end
			if (spans_sent % 25 == 0) sender_choppy = ($urandom_range(0, 2) != 0);
			quiet_tail = (spans_sent >= SPAN_COUNT - QUIET_SPANS);
			maybe_idle();
			offer_span(random_span());
		end

		// Let the last words out, then keep clocking to catch any late misbehaviour.
		drain_words();
		repeat (8) @(posedge clk);

		$display("Covered %0d span transactions (%0d reversed) and %0d word transactions,",
			spans_sent, empty_spans, words_checked);
		$display("with a %0d-cycle output hold-off, a mid-run drain and a stall-free tail.",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("Timed out with %0d word transactions still expected", words_pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ gdram_span_fill_unit.f @@
src/gdsf_pkg.sv
src/gdsf_front.sv
src/gdsf_queue.sv
src/gdsf_back.sv
src/gdram_span_fill_unit.sv
tb/gdsf_span_checker.sv
tb/testbench.sv
